>>> rtl/sha1md_pkg.sv
// shared types, constants and helpers for the sha-1 message digest block
`default_nettype none
package sha1md_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;
  localparam int ROUND_W     = 7;
  localparam int POS_W       = 6;
  localparam int LEN_W       = 64;

  // byte position where the length field starts
  localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
  localparam logic [POS_W-1:0] LAST_POS = 6'd63;
  localparam logic [7:0]       PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    GRP_CH  = 2'd0,
    GRP_P0  = 2'd1,
    GRP_MAJ = 2'd2,
    GRP_P1  = 2'd3
  } grp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_FILL,
    S_LEN,
    S_LOAD,
    S_ROUND,
    S_MERGE,
    S_OUT
  } state_t;

  // what follows a compression
  typedef enum logic [1:0] {
    PH_DATA,
    PH_SPILL,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic put_data;
    logic put_pad;
    logic fill;
    logic write_len;
    logic load_work;
    logic round;
    logic merge;
    logic load_out;
    grp_t grp;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } stat_t;

  function automatic logic [31:0] round_k(input grp_t g);
    logic [31:0] k;
    case (g)
      GRP_CH:  k = 32'h5A827999;
      GRP_P0:  k = 32'h6ED9EBA1;
      GRP_MAJ: k = 32'h8F1BBCDC;
      GRP_P1:  k = 32'hCA62C1D6;
      default: k = 32'h5A827999;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input grp_t g, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (g)
      GRP_CH:  f = (b & c) | (~b & d);
      GRP_MAJ: f = (b & c) | (b & d) | (c & d);
      GRP_P0:  f = b ^ c ^ d;
      GRP_P1:  f = b ^ c ^ d;
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha1_message_digest_top.sv
// top level of the streaming sha-1 message digest block
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, data_byte, has_byte, | one message byte and/or end
//          | last                                     | of message per beat
//  out     | out_valid, out_ready, digest_word0..4    | one 160-bit digest per beat
//
//  a beat without last is taken in idle; every 64th byte adds a compression
//  (work load, the rounds through the single round unit, chain merge)
//  a beat with last adds the pad byte, zero fill at one word a cycle and the
//  length write plus one or two compressions, then the output register load
//  synchronous reset restores the initial chaining values, clears the byte
//  position and length; no clearing pass
//  input is taken while a digest waits at the output; only the hand-off of
//  the next digest waits for out_ready
`default_nettype none
module sha1_message_digest_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last,
  // digest beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word0,
  output logic [31:0]      digest_word1,
  output logic [31:0]      digest_word2,
  output logic [31:0]      digest_word3,
  output logic [31:0]      digest_word4
);
  import sha1md_pkg::*;

  // command bundle from the sequencer, status back from the datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: packing, pad and length insertion, round count, output slot
  sha1md_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .has_byte  (has_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: block words as schedule window, one round per cycle,
  // chaining values and the digest output register
  sha1md_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .stat         (stat),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

endmodule
`default_nettype wire

>>> rtl/sha1md_ctrl.sv
// controller: sequences packing, padding, rounds and digest hand-off
`default_nettype none
module sha1md_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           has_byte,
  input  wire logic           last,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire sha1md_pkg::stat_t stat,
  output sha1md_pkg::cmd_t    cmd
);
  import sha1md_pkg::*;

  state_t               state, state_next;
  phase_t               phase, phase_next;
  logic                 last_q, last_q_next;
  logic [ROUND_W-1:0]   count, count_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DATA;
      last_q    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      last_q    <= last_q_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    last_q_next = last_q;
    count_next  = count;
    cmd         = '0;
    in_ready    = 1'b0;

    if (count < ROUND_W'(20))      cmd.grp = GRP_CH;
    else if (count < ROUND_W'(40)) cmd.grp = GRP_P0;
    else if (count < ROUND_W'(60)) cmd.grp = GRP_MAJ;
    else                           cmd.grp = GRP_P1;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.put_data = has_byte;
          last_q_next  = last;
          if (has_byte && stat.pos == LAST_POS) begin
            phase_next = PH_DATA;
            state_next = S_LOAD;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.put_pad = 1'b1;
        if (stat.pos == LAST_POS) begin
          phase_next = PH_SPILL;
          state_next = S_LOAD;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (stat.pos == LEN_POS) begin
          state_next = S_LEN;
        end else begin
          cmd.fill = 1'b1;
          if (stat.pos[POS_W-1:2] == '1) begin
            phase_next = PH_SPILL;
            state_next = S_LOAD;
          end
        end
      end
      S_LEN: begin
        cmd.write_len = 1'b1;
        phase_next    = PH_FINAL;
        state_next    = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_work = 1'b1;
        count_next    = '0;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        count_next = count + ROUND_W'(1);
        if (count == ROUND_W'(ROUNDS - 1)) begin
          count_next = '0;
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        case (phase)
          PH_DATA:  state_next = last_q ? S_PAD : S_IDLE;
          PH_SPILL: state_next = S_FILL;
          PH_FINAL: state_next = S_OUT;
          default:  state_next = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out)     out_valid_next = 1'b1;
    else if (out_ready)   out_valid_next = 1'b0;
  end

  // a fresh digest never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("digest loaded over a waiting beat");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> count < ROUND_W'(ROUNDS))
    else $error("round counter out of range");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_LEN |-> stat.pos == LEN_POS)
    else $error("length written at wrong position");

  a_final_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE && phase == PH_FINAL) |=> state == S_OUT)
    else $error("final compression did not lead to output");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> !in_ready)
    else $error("input taken during compression");

endmodule
`default_nettype wire

>>> rtl/sha1md_dp.sv
// datapath: block packing, message schedule, round registers and chaining values
`default_nettype none
module sha1md_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sha1md_pkg::cmd_t cmd,
  input  wire logic [7:0]      data_byte,
  output sha1md_pkg::stat_t    stat,
  output logic [31:0]          digest_word0,
  output logic [31:0]          digest_word1,
  output logic [31:0]          digest_word2,
  output logic [31:0]          digest_word3,
  output logic [31:0]          digest_word4
);
  import sha1md_pkg::*;

  logic [31:0]       blk [BLOCK_WORDS];
  logic [31:0]       chain [5];
  logic [31:0]       wa, wb, wc, wd, we;
  logic [POS_W-1:0]  pos;
  logic [LEN_W-1:0]  len;

  logic [7:0]        put_val;
  logic [3:0]        wi;
  logic [4:0]        sh;
  logic [31:0]       put_word;
  logic [31:0]       sched_new;
  logic [31:0]       t_sum;

  assign stat.pos = pos;
  assign wi       = pos[POS_W-1:2];
  assign sh       = {~pos[1:0], 3'b000};
  assign put_val  = cmd.put_pad ? PAD_BYTE : data_byte;
  assign put_word = (pos[1:0] == 2'b00) ? ({24'd0, put_val} << sh)
                                        : (blk[wi] | ({24'd0, put_val} << sh));

  // w[t+16] from the window w[t..t+15]
  assign sched_new = {blk[0][31:0] ^ blk[2] ^ blk[8] ^ blk[13]} << 1
                   | (blk[0] ^ blk[2] ^ blk[8] ^ blk[13]) >> 31;

  assign t_sum = {wa[26:0], wa[31:27]} + round_f(cmd.grp, wb, wc, wd)
               + we + blk[0] + round_k(cmd.grp);

  // control-side state: position, length, chaining values
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      len <= '0;
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
    end else if (cmd.load_out) begin
      pos <= '0;
      len <= '0;
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
    end else begin
      if (cmd.put_data || cmd.put_pad) pos <= pos + POS_W'(1);
      if (cmd.fill) pos <= {wi + 4'd1, 2'b00};
      if (cmd.put_data) len <= len + LEN_W'(8);
      if (cmd.merge) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
    end
  end

  // block words double as the schedule window
  always_ff @(posedge clk) begin
    if (cmd.put_data || cmd.put_pad) begin
      blk[wi] <= put_word;
    end else if (cmd.fill) begin
      if (pos[1:0] == 2'b00) blk[wi] <= '0;
    end else if (cmd.write_len) begin
      blk[14] <= len[63:32];
      blk[15] <= len[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) blk[i] <= blk[i+1];
      blk[BLOCK_WORDS-1] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round) begin
      wa <= t_sum;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      digest_word0 <= chain[0];
      digest_word1 <= chain[1];
      digest_word2 <= chain[2];
      digest_word3 <= chain[3];
      digest_word4 <= chain[4];
    end
  end

endmodule
`default_nettype wire

>>> bench/sha1_digest_checker.sv
// checker for the sha-1 digest block: predicts digests from input beats and compares them
`timescale 1ns / 1ps
module sha1_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] digest_word0,
  input  wire logic [31:0] digest_word1,
  input  wire logic [31:0] digest_word2,
  input  wire logic [31:0] digest_word3,
  input  wire logic [31:0] digest_word4,
  output int               mismatches,
  output int               pending
);

  typedef logic [4:0][31:0] digest_t;

  localparam digest_t CHAIN_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };
  localparam logic [7:0] MSG_PAD       = 8'h80;
  localparam logic [5:0] LEN_FIELD_POS = 6'd56;

  digest_t     chain;
  logic [31:0] blk [16];
  logic [5:0]  pos;
  logic [63:0] bit_len;
  digest_t     expected_digests [$];
  digest_t     want;
  digest_t     got;
  int          fail_total;
  int          k;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic note_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // big-endian packing, first byte of a word lands in bits 31..24
  task automatic put_byte(input logic [7:0] v);
    if (pos[1:0] == 2'd0) blk[pos[5:2]] = '0;
    blk[pos[5:2]] = blk[pos[5:2]] | ({24'd0, v} << (24 - 8 * pos[1:0]));
    pos = pos + 6'd1;
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, x;
    int          r;
    for (r = 0; r < 16; r++) w[r] = blk[r];
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
        w[r % 16] = rotl(x, 1);
      end
      if (r < 20) f = (b & c) | (~b & d);
      else if (r >= 40 && r < 60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      x = rotl(a, 5) + f + e + w[r % 16] + ROUND_K[r / 20];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = x;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chain   = CHAIN_INIT;
      pos     = '0;
      bit_len = '0;
      expected_digests.delete();
    end else begin
      // a digest leaving now belongs to an earlier message than any last beat at this edge
      if (out_valid && out_ready) begin
        got = {digest_word4, digest_word3, digest_word2, digest_word1, digest_word0};
        if (expected_digests.size() == 0) begin
          note_failure($sformatf("digest beat with nothing expected: %h", got));
        end else begin
          want = expected_digests.pop_front();
          for (k = 0; k < 5; k++) begin
            if (got[k] !== want[k])
              note_failure($sformatf("digest_word%0d mismatch: expected %08h, got %08h",
                                     k, want[k], got[k]));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (has_byte) begin
          put_byte(data_byte);
          bit_len = bit_len + 64'd8;
          if (pos == 6'd0) compress_block();
        end
        if (last) begin
          put_byte(MSG_PAD);
          if (pos == 6'd0) begin
            compress_block();
          end else if (pos > LEN_FIELD_POS) begin
            while (pos != 6'd0) put_byte(8'h00);
            compress_block();
          end
          while (pos != 6'd0 && pos < LEN_FIELD_POS) put_byte(8'h00);
          // pos back at zero: the length goes into a block of its own
          if (pos == 6'd0) begin
            for (k = 0; k < 14; k++) blk[k] = '0;
          end
          blk[14] = bit_len[63:32];
          blk[15] = bit_len[31:0];
          compress_block();
          expected_digests.push_back(chain);
          chain   = CHAIN_INIT;
          pos     = '0;
          bit_len = '0;
        end
      end
    end
    mismatches <= fail_total;
    pending    <= expected_digests.size();
  end

endmodule

>>> bench/sha1_message_digest_top_tb.sv
// top of the sha-1 digest bench: clock, reset, message stimulus and verdict
`timescale 1ns / 1ps
module sha1_message_digest_top_tb;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte  = 1'b0;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  int mismatches;
  int pending;

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // beats that carry a byte or end a message; pure no-op beats are not counted
  int beats_sent = 0;

  sha1_message_digest_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

  sha1_digest_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // digest side backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // sends an input beat; called right after posedge clk. valid is dropped only in
  // an idle gap, so back-to-back beats keep it high without a glitch
  task automatic send_beat(input logic [7:0] b, input logic hb, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    last      <= fin;
    // in_ready read here is its value before the edge, same as the block saw
    do @(posedge clk); while (!in_ready);
    if (hb || fin) beats_sent++;
  endtask

  // one message of len random bytes; the end either rides on the final byte
  // or comes as a separate beat without a byte
  task automatic send_message(input int len, input bit end_on_byte);
    int i;
    for (i = 0; i < len; i++) begin
      // occasional beat with neither byte nor end, its data must be ignored
      if ($urandom_range(19) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int ph;
    int len;
    int w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 0 idle rates apply to the directed beats as well
    send_idle_pct <= 21;
    recv_idle_pct <= 53;

    // empty message, with junk on data_byte that must be ignored
    send_beat(8'h5A, 1'b0, 1'b1);
    // neither byte nor end: nothing may happen
    send_beat(8'hFF, 1'b0, 1'b0);
    // "abc", end carried by the final byte
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // byte extremes, end as a separate beat
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    // single all-ones byte with end
    send_beat(8'hFF, 1'b1, 1'b1);
    // no-op, then two empty messages back to back
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);

    // three phases: receiver idles more, then sender idles more, then no idling
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct <= 21;
          recv_idle_pct <= 53;
        end
        1: begin
          send_idle_pct <= 53;
          recv_idle_pct <= 21;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      while (beats_sent < (ph + 1) * 550) begin
        // lengths: often short, many near the padding boundaries
        // (55/56 bytes decide one or two final blocks, 64 fills a block)
        case ($urandom_range(9))
          0, 1, 2, 3: len = $urandom_range(16);
          4, 5, 6: begin
            case ($urandom_range(11))
              0:       len = 54;
              1:       len = 55;
              2:       len = 56;
              3:       len = 57;
              4:       len = 63;
              5:       len = 64;
              6:       len = 65;
              7:       len = 118;
              8:       len = 119;
              9:       len = 120;
              10:      len = 127;
              default: len = 128;
            endcase
          end
          default: len = $urandom_range(140);
        endcase
        send_message(len, (len != 0) && ($urandom_range(1) == 1));
      end
    end
    in_valid <= 1'b0;

    // let the checker's count take in the final beat before the drain starts
    @(posedge clk);
    @(posedge clk);
    // drain outstanding digests; the bound sits far above two compressions
    // plus padding plus receiver stalls
    for (w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (300) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
